FILE: rtl/core/ilffa_pkg.sv
// ----------------------------------------------------------------------------
// ilffa_pkg
// Shared types, constants and address helpers for the boundary-tag allocator.
// ----------------------------------------------------------------------------
package ilffa_pkg;

  localparam int ARENA_BYTES = 65536;
  localparam int TAG_DEPTH   = ARENA_BYTES / 8;
  localparam int TAG_AW      = $clog2(TAG_DEPTH);
  localparam int SZ_W        = 13;
  localparam int TAG_W       = SZ_W + 1;
  localparam int BP_W        = 17;
  localparam int VIS_W       = 12;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [BP_W-1:0]  BASE_BP   = BP_W'(32);
  localparam logic [BP_W:0]    LAST_BP   = (BP_W + 1)'(ARENA_BYTES - 8);
  localparam logic [SZ_W-1:0]  MIN_UNITS = SZ_W'(2);
  localparam logic [VIS_W-1:0] VISIT_MAX = VIS_W'(4095);

  localparam int FREE_BYTES = (ARENA_BYTES - 32) & ~15;
  localparam int FREE_UNITS = FREE_BYTES / 16;
  localparam int INIT_N     = 5;

  localparam logic [TAG_W-1:0] PRO_TAG  = TAG_W'(3);
  localparam logic [TAG_W-1:0] FREE_TAG = TAG_W'(FREE_UNITS * 2);
  localparam logic [TAG_W-1:0] EPI_TAG  = TAG_W'(1);

  typedef struct packed {
    logic              re;
    logic [TAG_AW-1:0] raddr;
    logic              we;
    logic [TAG_AW-1:0] waddr;
    logic [TAG_W-1:0]  wdata;
  } tag_req_t;

  typedef struct packed {
    logic             ok;
    logic [15:0]      payload_offset;
    logic [VIS_W-1:0] blocks_visited;
    logic [BP_W-1:0]  reach_mark;
  } res_t;

  function automatic logic [TAG_AW-1:0] hdr_word(input logic [BP_W-1:0] bp);
    logic [BP_W-4:0] w;
    w = bp[BP_W-1:3] - (BP_W - 3)'(1);
    return w[TAG_AW-1:0];
  endfunction

  function automatic logic [TAG_AW-1:0] ftr_word(input logic [BP_W-1:0] blk_end);
    logic [BP_W-4:0] w;
    w = blk_end[BP_W-1:3] - (BP_W - 3)'(2);
    return w[TAG_AW-1:0];
  endfunction

  function automatic logic [BP_W-1:0] units_to_bytes(input logic [SZ_W-1:0] u);
    return {u, 4'b0000};
  endfunction

  function automatic logic [TAG_AW-1:0] init_addr(input logic [2:0] idx);
    logic [TAG_AW-1:0] a;
    unique case (idx)
      3'd0:    a = TAG_AW'(1);
      3'd1:    a = TAG_AW'(2);
      3'd2:    a = TAG_AW'(3);
      3'd3:    a = TAG_AW'((32 + FREE_BYTES) / 8 - 2);
      default: a = TAG_AW'((24 + FREE_BYTES) / 8);
    endcase
    return a;
  endfunction

  function automatic logic [TAG_W-1:0] init_data(input logic [2:0] idx);
    logic [TAG_W-1:0] d;
    unique case (idx)
      3'd0, 3'd1: d = PRO_TAG;
      3'd2, 3'd3: d = FREE_TAG;
      default:    d = EPI_TAG;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/core/ilffa_tag_ram.sv
// ----------------------------------------------------------------------------
// ilffa_tag_ram
// Tag word store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ilffa_tag_ram (
  input  logic                            clk,
  input  ilffa_pkg::tag_req_t             req,
  output logic [ilffa_pkg::TAG_W-1:0]     rdata
);

  logic [ilffa_pkg::TAG_W-1:0] mem [ilffa_pkg::TAG_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

FILE: rtl/core/ilffa_ctrl.sv
// ----------------------------------------------------------------------------
// ilffa_ctrl
// Sequencer: tag store setup, first-fit walk, split, free with merging.
// ----------------------------------------------------------------------------
module ilffa_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [15:0]                   in_req,
  input  logic [15:0]                   in_off,
  output ilffa_pkg::tag_req_t           ram_req,
  input  logic [ilffa_pkg::TAG_W-1:0]   ram_rdata,
  output logic                          res_valid,
  input  logic                          res_ready,
  output ilffa_pkg::res_t               res
);

  localparam int SZ_W  = ilffa_pkg::SZ_W;
  localparam int BP_W  = ilffa_pkg::BP_W;
  localparam int VIS_W = ilffa_pkg::VIS_W;
  localparam int TAG_W = ilffa_pkg::TAG_W;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_MRGP  = 3'd3;
  localparam logic [2:0] S_MRGN  = 3'd4;
  localparam logic [2:0] S_WRITE = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [2:0]       init_cnt_r, init_cnt_nxt;
  logic             op_r, op_nxt;
  logic [SZ_W-1:0]  need_r, need_nxt;
  logic [15:0]      off_r, off_nxt;
  logic [BP_W-1:0]  bp_r, bp_nxt;
  logic [SZ_W-1:0]  sz_r, sz_nxt;
  logic [VIS_W-1:0] vis_r, vis_nxt;
  logic             ok_r, ok_nxt;
  logic [15:0]      pay_r, pay_nxt;
  logic [BP_W-1:0]  reach_r, reach_nxt;
  logic [TAG_W-1:0] pf_r, pf_nxt;
  logic [BP_W-1:0]  a_bp_r, a_bp_nxt;
  logic [SZ_W-1:0]  a_sz_r, a_sz_nxt;
  logic             a_al_r, a_al_nxt;
  logic             b_en_r, b_en_nxt;
  logic [SZ_W-1:0]  b_sz_r, b_sz_nxt;
  logic [1:0]       wstep_r, wstep_nxt;

  logic [BP_W-1:0]  need_bytes;
  logic [SZ_W-1:0]  need_units;
  logic [SZ_W-1:0]  h_sz;
  logic             h_al;
  logic [BP_W:0]    bp_sum;
  logic [SZ_W-1:0]  rem;
  logic [BP_W-1:0]  used_end;
  logic [BP_W-1:0]  b_bp;
  logic [SZ_W-1:0]  p_sz;
  logic             p_al;
  logic [SZ_W-1:0]  merge_sz;
  logic [BP_W-1:0]  merge_bp;

  always_comb begin
    need_bytes = ({1'b0, in_req} + BP_W'(31)) & ~BP_W'(15);
    need_units = need_bytes[BP_W-1:4];
    if (need_units < ilffa_pkg::MIN_UNITS) begin
      need_units = ilffa_pkg::MIN_UNITS;
    end
    h_sz   = ram_rdata[TAG_W-1:1];
    h_al   = ram_rdata[0];
    bp_sum = {1'b0, bp_r} + {1'b0, ilffa_pkg::units_to_bytes(h_sz)};
    rem    = h_sz - need_r;
    b_bp   = a_bp_r + ilffa_pkg::units_to_bytes(a_sz_r);
    p_sz   = pf_r[TAG_W-1:1];
    p_al   = pf_r[0];
    if (!p_al && (ilffa_pkg::units_to_bytes(p_sz) > bp_r)) begin
      p_al = 1'b1;
    end
    merge_sz = sz_r;
    merge_bp = bp_r;
    if (!(p_al && h_al)) begin
      if (!h_al) begin
        merge_sz = merge_sz + h_sz;
      end
      if (!p_al) begin
        merge_sz = merge_sz + p_sz;
        merge_bp = merge_bp - ilffa_pkg::units_to_bytes(p_sz);
      end
    end
    if (rem >= ilffa_pkg::MIN_UNITS) begin
      used_end = bp_r + ilffa_pkg::units_to_bytes(need_r);
    end else begin
      used_end = bp_r + ilffa_pkg::units_to_bytes(h_sz);
    end
  end

  always_comb begin
    state_nxt    = state_r;
    init_cnt_nxt = init_cnt_r;
    op_nxt       = op_r;
    need_nxt     = need_r;
    off_nxt      = off_r;
    bp_nxt       = bp_r;
    sz_nxt       = sz_r;
    vis_nxt      = vis_r;
    ok_nxt       = ok_r;
    pay_nxt      = pay_r;
    reach_nxt    = reach_r;
    pf_nxt       = pf_r;
    a_bp_nxt     = a_bp_r;
    a_sz_nxt     = a_sz_r;
    a_al_nxt     = a_al_r;
    b_en_nxt     = b_en_r;
    b_sz_nxt     = b_sz_r;
    wstep_nxt    = wstep_r;
    ram_req      = '0;
    in_ready     = 1'b0;
    res_valid    = 1'b0;

    unique case (state_r)
      S_INIT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = ilffa_pkg::init_addr(init_cnt_r);
        ram_req.wdata = ilffa_pkg::init_data(init_cnt_r);
        init_cnt_nxt  = init_cnt_r + 3'd1;
        if (init_cnt_r == 3'(ilffa_pkg::INIT_N - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt   = in_op;
          need_nxt = need_units;
          off_nxt  = in_off;
          bp_nxt   = ilffa_pkg::BASE_BP;
          vis_nxt  = '0;
          ok_nxt   = 1'b0;
          pay_nxt  = '0;
          if (in_op == ilffa_pkg::OP_ALLOC || {1'b0, in_off} >= ilffa_pkg::BASE_BP) begin
            ram_req.re    = 1'b1;
            ram_req.raddr = ilffa_pkg::hdr_word(ilffa_pkg::BASE_BP);
            state_nxt     = S_WALK;
          end else begin
            ok_nxt    = (in_off == 16'd0);
            state_nxt = S_DONE;
          end
        end
      end
      S_WALK: begin
        if (h_sz == '0) begin
          state_nxt = S_DONE;
        end else if (op_r == ilffa_pkg::OP_ALLOC) begin
          if (vis_r < ilffa_pkg::VISIT_MAX) begin
            vis_nxt = vis_r + VIS_W'(1);
          end
          if (!h_al && (h_sz >= need_r)) begin
            ok_nxt    = 1'b1;
            pay_nxt   = bp_r[15:0];
            a_bp_nxt  = bp_r;
            a_al_nxt  = 1'b1;
            wstep_nxt = 2'd0;
            if (rem >= ilffa_pkg::MIN_UNITS) begin
              a_sz_nxt = need_r;
              b_en_nxt = 1'b1;
              b_sz_nxt = rem;
            end else begin
              a_sz_nxt = h_sz;
              b_en_nxt = 1'b0;
            end
            if (used_end > reach_r) begin
              reach_nxt = used_end;
            end
            state_nxt = S_WRITE;
          end else if (bp_sum > ilffa_pkg::LAST_BP) begin
            state_nxt = S_DONE;
          end else begin
            bp_nxt        = bp_sum[BP_W-1:0];
            ram_req.re    = 1'b1;
            ram_req.raddr = ilffa_pkg::hdr_word(bp_sum[BP_W-1:0]);
          end
        end else begin
          if (bp_r == {1'b0, off_r}) begin
            if (h_al) begin
              sz_nxt        = h_sz;
              ram_req.re    = 1'b1;
              ram_req.raddr = ilffa_pkg::ftr_word(bp_r);
              state_nxt     = S_MRGP;
            end else begin
              state_nxt = S_DONE;
            end
          end else if ((bp_sum > {2'b00, off_r}) || (bp_sum > ilffa_pkg::LAST_BP)) begin
            state_nxt = S_DONE;
          end else begin
            bp_nxt        = bp_sum[BP_W-1:0];
            ram_req.re    = 1'b1;
            ram_req.raddr = ilffa_pkg::hdr_word(bp_sum[BP_W-1:0]);
          end
        end
      end
      S_MRGP: begin
        pf_nxt        = ram_rdata;
        ram_req.re    = 1'b1;
        ram_req.raddr = ilffa_pkg::hdr_word(bp_r + ilffa_pkg::units_to_bytes(sz_r));
        state_nxt     = S_MRGN;
      end
      S_MRGN: begin
        ok_nxt    = 1'b1;
        a_bp_nxt  = merge_bp;
        a_sz_nxt  = merge_sz;
        a_al_nxt  = 1'b0;
        b_en_nxt  = 1'b0;
        wstep_nxt = 2'd0;
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        ram_req.we = 1'b1;
        wstep_nxt  = wstep_r + 2'd1;
        unique case (wstep_r)
          2'd0: begin
            ram_req.waddr = ilffa_pkg::hdr_word(a_bp_r);
            ram_req.wdata = {a_sz_r, a_al_r};
          end
          2'd1: begin
            ram_req.waddr = ilffa_pkg::ftr_word(b_bp);
            ram_req.wdata = {a_sz_r, a_al_r};
            if (!b_en_r) begin
              state_nxt = S_DONE;
            end
          end
          2'd2: begin
            ram_req.waddr = ilffa_pkg::hdr_word(b_bp);
            ram_req.wdata = {b_sz_r, 1'b0};
          end
          default: begin
            ram_req.waddr = ilffa_pkg::ftr_word(b_bp + ilffa_pkg::units_to_bytes(b_sz_r));
            ram_req.wdata = {b_sz_r, 1'b0};
            state_nxt     = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_comb begin
    res.ok             = ok_r;
    res.payload_offset = pay_r;
    res.blocks_visited = vis_r;
    res.reach_mark     = reach_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT;
      init_cnt_r <= '0;
      reach_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      init_cnt_r <= init_cnt_nxt;
      reach_r    <= reach_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    need_r  <= need_nxt;
    off_r   <= off_nxt;
    bp_r    <= bp_nxt;
    sz_r    <= sz_nxt;
    vis_r   <= vis_nxt;
    ok_r    <= ok_nxt;
    pay_r   <= pay_nxt;
    pf_r    <= pf_nxt;
    a_bp_r  <= a_bp_nxt;
    a_sz_r  <= a_sz_nxt;
    a_al_r  <= a_al_nxt;
    b_en_r  <= b_en_nxt;
    b_sz_r  <= b_sz_nxt;
    wstep_r <= wstep_nxt;
  end

endmodule

FILE: rtl/core/implicit_list_first_fit_allocator.sv
// ----------------------------------------------------------------------------
// implicit_list_first_fit_allocator
// Boundary-tag first-fit allocator over a 64 KiB arena with an implicit list.
//
// The input channel takes one beat per operation: in_tuser selects allocate
// (0) or free (1), in_tdata carries the request size and the offset to free.
// The output channel returns exactly one beat per operation with the status,
// the payload offset, the blocks an allocate walked (zero for a free) and the
// high-water mark. Operations are handled one at a time. An allocate is accepted,
// walks the blocks, makes 2 tag writes (4 when the block is split) and posts the
// result; a free is accepted, walks up to the freed block, makes 2 neighbor tag
// reads and 2 tag writes and posts the result. A failed operation skips the reads
// and writes; a null free or an offset below the first block goes straight from
// accept to the result. A result beat shows on out_tvalid in the cycle after the
// sequencer hands it over. The walk reads one tag a cycle, so throughput follows
// the chain. After reset the block writes the prologue, the initial free block
// and the epilogue tags, with in_tready low. A result waits in the output
// register while out_tready is low; the next operation is taken as soon as the
// sequencer is free, and it stalls only at its own result.
// ----------------------------------------------------------------------------
module implicit_list_first_fit_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // request_bytes [15:0], freed_offset [31:16]
  input  logic        in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // payload_offset [15:0], blocks_visited [27:16],
                                  // reach_mark [44:28], zero [47:45]
  output logic        out_tuser   // ok
);

  ilffa_pkg::tag_req_t               ram_req;
  logic [ilffa_pkg::TAG_W-1:0]       ram_rdata;
  logic                              res_valid;
  logic                              res_ready;
  ilffa_pkg::res_t                   res;
  logic                              out_valid_r;
  ilffa_pkg::res_t                   out_res_r;

  ilffa_tag_ram u_tag_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  ilffa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_req    (in_tdata[15:0]),
    .in_off    (in_tdata[31:16]),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.ok;
  assign out_tdata  = {3'b000, out_res_r.reach_mark, out_res_r.blocks_visited,
                       out_res_r.payload_offset};

endmodule
